// File: hdl/rfhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhb_pkg
// Shared types, widths and register codes of the radial falloff height brush.
// ----------------------------------------------------------------------------
package rfhb_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 16;
   localparam int HEIGHT_W   = 32;
   localparam int RAD_W      = 28;
   localparam int OUTER_W    = RAD_W + 1;
   localparam int SQ_W       = 2 * OUTER_W;
   localparam int OFS_W      = HEIGHT_W + 2;
   localparam int AXIS_W     = 31;
   localparam int SUM_W      = 2 * AXIS_W;
   localparam int INFL_W     = FRAC_BITS + 1;
   localparam int ROOT_STEPS = OUTER_W;
   localparam int PROD_W     = INFL_W + 1 + HEIGHT_W;
   localparam int MPROD_W    = 2 * HEIGHT_W + 1;
   localparam int RES_W      = MPROD_W - FRAC_BITS + 1;
   localparam logic [OFS_W-1:0] FAR_LIMIT = OFS_W'(1) << 30;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Z      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RADIUS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLOFF_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_MODE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEVEL  = 3'd6;

   localparam logic MODE_ELEVATE = 1'b0;
   localparam logic MODE_FLATTEN = 1'b1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic signed [COORD_W-1:0]  cell_x;
      logic signed [COORD_W-1:0]  cell_z;
      logic signed [HEIGHT_W-1:0] base_height;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] new_height;
      logic                       touched;
      logic                       overflowed;
   } rsp_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] centre_x;
      logic signed [HEIGHT_W-1:0] centre_z;
      logic [RAD_W-1:0]           inner_radius;
      logic [RAD_W-1:0]           falloff_width;
      logic signed [HEIGHT_W-1:0] strength;
      logic                       brush_mode;
      logic signed [HEIGHT_W-1:0] target_level;
   } cfg_type;

   // classified cell handed from front to back
   typedef struct packed {
      logic [SQ_W-1:0]            dist_sq;
      logic                       in_core;
      logic                       touched;
      logic signed [HEIGHT_W-1:0] base;
   } cell_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hdl/rfhb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhb_front
// Accepts cells, squares the offsets and classifies inside, band or untouched.
// ----------------------------------------------------------------------------
module rfhb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rfhb_pkg::req_type req,
   input  rfhb_pkg::cfg_type cfg,
   input  rfhb_pkg::qstat_type qstat,
   output logic              push,
   output rfhb_pkg::cell_type item
);
   import rfhb_pkg::*;

   logic [3:0] valid_ff, valid_in;
   logic       advance;

   logic [AXIS_W-1:0]          ax_ff, az_ff;
   logic                       far1_ff, far2_ff, far3_ff;
   logic signed [HEIGHT_W-1:0] base1_ff, base2_ff, base3_ff;
   logic [SUM_W-1:0]           sqx_ff, sqz_ff, s_ff;
   logic [SQ_W-1:0]            rr_ff, oo_ff;
   cell_type                   item_ff;

   logic signed [OFS_W-1:0] cx, cz, dx, dz;
   logic [OFS_W-1:0]        ax, az;
   logic [OUTER_W-1:0]      outer;

   // the whole front moves together unless its last stage holds a cell and the queue is full
   assign advance = !(valid_ff[3] && qstat.full);
   assign busy    = !advance;
   assign push    = valid_ff[3] && !qstat.full;
   assign item    = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // offsets from the brush centre
   always_comb begin
      cx = OFS_W'(req.cell_x) <<< FRAC_BITS;
      cz = OFS_W'(req.cell_z) <<< FRAC_BITS;
      dx = OFS_W'(cfg.centre_x) - cx;
      dz = OFS_W'(cfg.centre_z) - cz;
      ax = dx[OFS_W-1] ? OFS_W'(-dx) : OFS_W'(dx);
      az = dz[OFS_W-1] ? OFS_W'(-dz) : OFS_W'(dz);
      outer = OUTER_W'(cfg.inner_radius) + OUTER_W'(cfg.falloff_width);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1: magnitudes and far check
         ax_ff    <= ax[AXIS_W-1:0];
         az_ff    <= az[AXIS_W-1:0];
         far1_ff  <= (ax > FAR_LIMIT) || (az > FAR_LIMIT);
         base1_ff <= req.base_height;
         // stage 2: squares
         sqx_ff   <= ax_ff * ax_ff;
         sqz_ff   <= az_ff * az_ff;
         far2_ff  <= far1_ff;
         base2_ff <= base1_ff;
         // stage 3: squared distance and radius bounds
         s_ff     <= sqx_ff + sqz_ff;
         rr_ff    <= SQ_W'(cfg.inner_radius) * SQ_W'(cfg.inner_radius);
         oo_ff    <= outer * outer;
         far3_ff  <= far2_ff;
         base3_ff <= base2_ff;
         // stage 4: classify
         item_ff.dist_sq <= s_ff[SQ_W-1:0];
         item_ff.in_core <= !far3_ff && (s_ff <= SUM_W'(rr_ff));
         item_ff.touched <= !far3_ff && ((s_ff <= SUM_W'(rr_ff)) ||
                            ((s_ff <= SUM_W'(oo_ff)) && (cfg.falloff_width != '0)));
         item_ff.base    <= base3_ff;
      end
   end

endmodule

// File: hdl/rfhb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhb_queue
// Two-entry queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module rfhb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfhb_pkg::cell_type push_item,
   input  logic               pop,
   output rfhb_pkg::cell_type head,
   output rfhb_pkg::qstat_type qstat
);
   import rfhb_pkg::*;

   cell_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/rfhb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhb_back
// Pipelined square root, falloff divider and height update.
// ----------------------------------------------------------------------------
module rfhb_back (
   input  logic               clock,
   input  logic               reset,
   input  rfhb_pkg::qstat_type qstat,
   input  rfhb_pkg::cell_type head,
   output logic               pop,
   input  rfhb_pkg::cfg_type  cfg,
   output logic               rsp_strobe,
   output rfhb_pkg::rsp_type  rsp_data
);
   import rfhb_pkg::*;

   localparam int DIV_STEPS = INFL_W;
   localparam int LAT = ROOT_STEPS + 1 + DIV_STEPS + 4;

   logic [LAT:0] valid_ff;

   // square root pipeline
   logic [SQ_W-1:0] sq_v_ff    [ROOT_STEPS+1];
   logic [SQ_W-1:0] sq_root_ff [ROOT_STEPS+1];
   cell_type        sq_item_ff [ROOT_STEPS+1];

   // divider pipeline
   logic [OUTER_W-1:0] dv_p_ff    [DIV_STEPS+1];
   logic [INFL_W-1:0]  dv_q_ff    [DIV_STEPS+1];
   cell_type           dv_item_ff [DIV_STEPS+1];

   logic [OUTER_W-1:0] root_dist, past;
   logic [RAD_W-1:0]   rem;
   logic [INFL_W-1:0]  infl;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [HEIGHT_W-1:0] factor_ff;
   logic signed [OFS_W-1:0]    diff_ff, elev_ff;
   logic signed [MPROD_W-1:0]  mprod_ff;
   logic signed [RES_W-1:0]    result;
   cell_type                   e1_ff, e2_ff, e3_ff;
   rsp_type                    rsp_ff;

   assign pop        = !qstat.empty;
   assign rsp_strobe = valid_ff[LAT];
   assign rsp_data   = rsp_ff;

   // valid shift line, the back never stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-1:0], !qstat.empty};
      end
   end

   // load the root pipeline from the queue head
   always_ff @(posedge clock) begin
      sq_v_ff[0]    <= head.dist_sq;
      sq_root_ff[0] <= '0;
      sq_item_ff[0] <= head;
   end

   // one root bit per stage
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial;
      assign trial = sq_root_ff[k] + BIT_K;
      always_ff @(posedge clock) begin
         if (sq_v_ff[k] >= trial) begin
            sq_v_ff[k+1]    <= sq_v_ff[k] - trial;
            sq_root_ff[k+1] <= (sq_root_ff[k] >> 1) + BIT_K;
         end else begin
            sq_v_ff[k+1]    <= sq_v_ff[k];
            sq_root_ff[k+1] <= sq_root_ff[k] >> 1;
         end
         sq_item_ff[k+1] <= sq_item_ff[k];
      end
   end

   // distance into the band and remaining width
   always_comb begin
      root_dist = sq_root_ff[ROOT_STEPS][OUTER_W-1:0];
      past = (root_dist > OUTER_W'(cfg.inner_radius)) ?
             root_dist - OUTER_W'(cfg.inner_radius) : '0;
      rem  = (past < OUTER_W'(cfg.falloff_width)) ?
             RAD_W'(OUTER_W'(cfg.falloff_width) - past) : '0;
   end

   always_ff @(posedge clock) begin
      dv_p_ff[0]    <= OUTER_W'(rem);
      dv_q_ff[0]    <= '0;
      dv_item_ff[0] <= sq_item_ff[ROOT_STEPS];
   end

   // restoring divide, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [OUTER_W-1:0] pin;
      logic               ge;
      if (j == 0) begin : g_first
         assign pin = dv_p_ff[j];
      end else begin : g_next
         assign pin = dv_p_ff[j] << 1;
      end
      assign ge = (pin >= OUTER_W'(cfg.falloff_width));
      always_ff @(posedge clock) begin
         dv_p_ff[j+1]    <= ge ? pin - OUTER_W'(cfg.falloff_width) : pin;
         dv_q_ff[j+1]    <= {dv_q_ff[j][INFL_W-2:0], ge};
         dv_item_ff[j+1] <= dv_item_ff[j];
      end
   end

   assign infl = dv_item_ff[DIV_STEPS].in_core ? (INFL_W'(1) << FRAC_BITS) :
                 dv_q_ff[DIV_STEPS];

   // force scaling and height update
   always_comb begin
      if (e3_ff.touched && (cfg.brush_mode == MODE_FLATTEN)) begin
         result = RES_W'(mprod_ff >>> FRAC_BITS) + RES_W'(e3_ff.base);
      end else begin
         result = RES_W'(elev_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= PROD_W'(signed'({1'b0, infl})) * PROD_W'(cfg.strength);
      e1_ff     <= dv_item_ff[DIV_STEPS];
      factor_ff <= HEIGHT_W'(prod_ff >>> FRAC_BITS);
      diff_ff   <= OFS_W'(cfg.target_level) - OFS_W'(e1_ff.base);
      e2_ff     <= e1_ff;
      mprod_ff  <= MPROD_W'(diff_ff) * MPROD_W'(factor_ff);
      elev_ff   <= OFS_W'(e2_ff.base) + OFS_W'(factor_ff);
      e3_ff     <= e2_ff;
      if (e3_ff.touched) begin
         rsp_ff.new_height <= result[HEIGHT_W-1:0];
         rsp_ff.touched    <= 1'b1;
         rsp_ff.overflowed <= !((&result[RES_W-1:HEIGHT_W-1]) ||
                                !(|result[RES_W-1:HEIGHT_W-1]));
      end else begin
         rsp_ff.new_height <= e3_ff.base;
         rsp_ff.touched    <= 1'b0;
         rsp_ff.overflowed <= 1'b0;
      end
   end

endmodule

// File: hdl/radial_falloff_height_brush.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_falloff_height_brush
// Per-cell heightmap brush with linear radial falloff, elevate or flatten.
// ----------------------------------------------------------------------------
// channel   ports                              handshake
// request   start, busy, req_data              taken when start && !busy
// result    rsp_strobe, rsp_data               one cycle, always taken
// config    csr_write_en, csr_index, csr_wdata written when csr_write_en
//
// one request per cycle while busy is low, through the 29-stage square root and
// the 17-stage divider in the back part.
// reset is synchronous; it clears the configuration registers to zero and empties the pipe.
// busy rises only if the front/back queue fills; the result side never stalls.
// ----------------------------------------------------------------------------
module radial_falloff_height_brush (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rfhb_pkg::req_type                  req_data,
   output logic                               rsp_strobe,
   output rfhb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [rfhb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rfhb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rfhb_pkg::*;

   cfg_type   cfg_ff;
   qstat_type qstat;
   cell_type  push_item, head;
   logic      push, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CENTRE_X:      cfg_ff.centre_x      <= csr_wdata;
            CSR_CENTRE_Z:      cfg_ff.centre_z      <= csr_wdata;
            CSR_INNER_RADIUS:  cfg_ff.inner_radius  <= csr_wdata[RAD_W-1:0];
            CSR_FALLOFF_WIDTH: cfg_ff.falloff_width <= csr_wdata[RAD_W-1:0];
            CSR_STRENGTH:      cfg_ff.strength      <= csr_wdata;
            CSR_BRUSH_MODE:    cfg_ff.brush_mode    <= csr_wdata[0];
            CSR_TARGET_LEVEL:  cfg_ff.target_level  <= csr_wdata;
            default: ;
         endcase
      end
   end

   rfhb_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .req   (req_data),
      .cfg   (cfg_ff),
      .qstat (qstat),
      .push  (push),
      .item  (push_item)
   );

   rfhb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   rfhb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (head),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // back drains every cycle, so the queue never fills
   a_queue_not_full: assert property (@(posedge clock) disable iff (reset)
      !qstat.full) else $error("front/back queue filled");

   // untouched cells pass through without an overflow flag
   a_untouched_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.touched |-> !rsp_data.overflowed)
      else $error("overflow flagged on untouched cell");

   // whenever the queue holds an entry, the back pops it
   a_pop_when_valid: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> pop) else $error("queue head not taken");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the radial falloff height brush. Walks a short table of directed
// cells and directed brush cases, then random cells over several brush settings,
// and checks each result strobe against typed-in values or an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import rfhb_pkg::*;

   localparam int LATENCY = 57;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // brush settings as the predictor sees them
   logic signed [31:0] brush_cx, brush_cz, brush_force, brush_target;
   logic [27:0]        brush_inner, brush_band;
   logic               brush_mode;

   rsp_type heights_due[$];
   int      mismatch_count;
   int      strobe_count;
   int      touched_count;
   int      flatten_count;
   int      idle_pct;

   // directed row: request, and an expected result typed in when known
   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } cell_row_type;

   radial_falloff_height_brush DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint floor_q(longint v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd4294967296;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return longint'(lo);
   endfunction

   // brush height for one cell under the current settings
   function automatic rsp_type brush_height(req_type r);
      rsp_type       o;
      longint        dx, dz, base, infl, factor, res;
      longint unsigned ax, az, s, rr, ww, outer, root_dist, past, rem;
      base = longint'(r.base_height);
      dx = longint'(brush_cx) - (longint'(r.cell_x) <<< FRAC_BITS);
      dz = longint'(brush_cz) - (longint'(r.cell_z) <<< FRAC_BITS);
      ax = dx < 0 ? -dx : dx;
      az = dz < 0 ? -dz : dz;
      rr = brush_inner;
      ww = brush_band;
      o.new_height = r.base_height;
      o.touched = 1'b0;
      o.overflowed = 1'b0;
      if (ax > (64'd1 << 30) || az > (64'd1 << 30)) return o;
      s = ax * ax + az * az;
      outer = rr + ww;
      if (s <= rr * rr) begin
         infl = 1 << FRAC_BITS;
      end else if (s <= outer * outer && ww != 0) begin
         root_dist = root_floor(s);
         past = root_dist > rr ? root_dist - rr : 0;
         rem = past < ww ? ww - past : 0;
         infl = longint'((rem << FRAC_BITS) / ww);
      end else begin
         return o;
      end
      factor = floor_q(infl * longint'(brush_force));
      if (brush_mode == MODE_ELEVATE) res = base + factor;
      else res = base + floor_q((longint'(brush_target) - base) * factor);
      o.new_height = res[31:0];
      o.touched = 1'b1;
      o.overflowed = (res > 64'sd2147483647 || res < -64'sd2147483648);
      return o;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_CENTRE_X:      brush_cx = val;
         CSR_CENTRE_Z:      brush_cz = val;
         CSR_INNER_RADIUS:  brush_inner = val[27:0];
         CSR_FALLOFF_WIDTH: brush_band = val[27:0];
         CSR_STRENGTH:      brush_force = val;
         CSR_BRUSH_MODE:    brush_mode = val[0];
         CSR_TARGET_LEVEL:  brush_target = val;
         default: ;
      endcase
   endtask

   task automatic load_brush(logic [31:0] cx, logic [31:0] cz, logic [31:0] inner,
                             logic [31:0] band, logic [31:0] force_q, logic m,
                             logic [31:0] target);
      write_reg(CSR_CENTRE_X, cx);
      write_reg(CSR_CENTRE_Z, cz);
      write_reg(CSR_INNER_RADIUS, inner);
      write_reg(CSR_FALLOFF_WIDTH, band);
      write_reg(CSR_STRENGTH, force_q);
      write_reg(CSR_BRUSH_MODE, {31'd0, m});
      write_reg(CSR_TARGET_LEVEL, target);
   endtask

   // wait for the pipe to drain before touching the registers
   task automatic drain_pipe();
      int guard;
      guard = 0;
      while (heights_due.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // send one request, with a random gap ahead of it; start stays high across
   // back-to-back requests
   task automatic send_cell(req_type r, bit known, rsp_type e);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      heights_due.push_back(known ? e : brush_height(r));
      if (brush_mode == MODE_FLATTEN) flatten_count++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         strobe_count++;
         if (heights_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = heights_due.pop_front();
            if (rsp_data.touched) touched_count++;
            if (rsp_data.new_height !== want.new_height ||
                rsp_data.touched !== want.touched ||
                rsp_data.overflowed !== want.overflowed) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected h=%h t=%b o=%b got h=%h t=%b o=%b",
                           want.new_height, want.touched, want.overflowed,
                           rsp_data.new_height, rsp_data.touched,
                           rsp_data.overflowed);
            end
         end
      end
   end

   function automatic req_type rand_cell(int spread);
      req_type r;
      int      cx, cz;
      cx = $signed(brush_cx) >>> FRAC_BITS;
      cz = $signed(brush_cz) >>> FRAC_BITS;
      if ($urandom_range(9) == 0) begin
         r.cell_x = 16'($urandom);
         r.cell_z = 16'($urandom);
      end else begin
         r.cell_x = 16'(cx + $signed($urandom_range(2 * spread)) - spread);
         r.cell_z = 16'(cz + $signed($urandom_range(2 * spread)) - spread);
      end
      r.base_height = $urandom_range(3) == 0 ? 32'($urandom) :
                      32'($signed($urandom_range(2 ** 24)) - 2 ** 23);
      return r;
   endfunction

   initial begin
      cell_row_type dir_rows[$];
      cell_row_type row;
      rsp_type   none;
      int        phase, n, spread;
      none = '0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      brush_cx = 0; brush_cz = 0; brush_force = 0; brush_target = 0;
      brush_inner = 0; brush_band = 0; brush_mode = MODE_ELEVATE;
      mismatch_count = 0; strobe_count = 0; touched_count = 0; flatten_count = 0;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: zero radius, origin cell inside with zero force
      row.r = '{cell_x: 16'sd0, cell_z: 16'sd0, base_height: 32'h12345678};
      row.known = 1; row.e = '{new_height: 32'h12345678, touched: 1'b1,
                               overflowed: 1'b0};
      dir_rows.push_back(row);
      // neighbor cell is outside a zero brush
      row.r = '{cell_x: 16'sd1, cell_z: 16'sd0, base_height: 32'h80000000};
      row.e = '{new_height: 32'h80000000, touched: 1'b0, overflowed: 1'b0};
      dir_rows.push_back(row);
      // far offset: extreme coordinates
      row.r = '{cell_x: 16'h8000, cell_z: 16'h7fff, base_height: 32'h7fffffff};
      row.e = '{new_height: 32'h7fffffff, touched: 1'b0, overflowed: 1'b0};
      dir_rows.push_back(row);
      foreach (dir_rows[i]) send_cell(dir_rows[i].r, 1, dir_rows[i].e);
      end_burst();
      drain_pipe();

      // elevate at max force: overflow, band edges, cell exactly on the radius
      load_brush(32'h0005_0000, 32'hfffb_0000, 32'h0003_0000, 32'h0004_0000,
                 32'h7fffffff, MODE_ELEVATE, 0);
      for (int k = -8; k <= 8; k++)
         send_cell('{cell_x: 16'(5 + k), cell_z: -16'sd5,
                     base_height: (k & 1) ? 32'h7fff0000 : 32'h80000000}, 0, none);
      end_burst();
      drain_pipe();

      // zero band, flatten, min force, large radius at the register extreme
      load_brush(32'h7fffffff, 32'h80000000, 32'h0fffffff, 32'h0, 32'h80000000,
                 MODE_FLATTEN, 32'h7fffffff);
      send_cell('{cell_x: 16'sd32767, cell_z: -16'sd32768, base_height: 32'h80000000},
                0, none);
      send_cell('{cell_x: 16'sd0, cell_z: 16'sd0, base_height: 32'h0}, 0, none);
      end_burst();
      drain_pipe();

      // random phases with various brushes and idling
      for (phase = 0; phase < 16; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 54;
            2: idle_pct = 27;
            default: idle_pct = 0;
         endcase
         spread = (phase % 3 == 0) ? 40 : 12;
         load_brush($urandom, $urandom,
                    phase == 5 ? 32'h0fffffff : $urandom_range(32'h000a_0000),
                    phase == 6 ? 32'h0 : phase == 7 ? 32'h0fffffff :
                    $urandom_range(32'h0010_0000),
                    phase % 5 == 0 ? $urandom : $urandom_range(32'h0004_0000) - 32'h0002_0000,
                    phase[0], $urandom);
         for (n = 0; n < 95; n++) send_cell(rand_cell(spread), 0, none);
         end_burst();
         drain_pipe();
      end

      $display("covered %0d results, %0d touched, %0d in flatten mode, 16 brush settings",
               strobe_count, touched_count, flatten_count);
      if (mismatch_count == 0 && heights_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d left over", mismatch_count, heights_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
